FILE: src/bri_pkg.sv
// ----------------------------------------------------------------------------
// bri_pkg: shared types and helpers for the bounded random integer sampler
// Holds the data widths, the register index codes, the request and response
// payload types and the restoring division step.
// ----------------------------------------------------------------------------
package bri_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  typedef logic [DataW-1:0]    word_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [StepCntW-1:0] step_cnt_t;

  // Configuration register indexes
  localparam cfg_idx_t RegLowBound   = cfg_idx_t'(0);
  localparam cfg_idx_t RegHighBound  = cfg_idx_t'(1);
  localparam cfg_idx_t RegNarrowMode = cfg_idx_t'(2);

  typedef struct packed {
    logic [DataW-1:0] random_word;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] sample_value;
  } rsp_t;

  // Threshold preparation after a register write
  typedef enum logic [2:0] {
    PrepReady  = 3'b001,
    PrepBounds = 3'b010,
    PrepDivide = 3'b100
  } prep_state_e;

  // Sign-extend the low half of a word
  function automatic word_t sext_half(word_t v);
    return {{(DataW-HalfW){v[HalfW-1]}}, v[HalfW-1:0]};
  endfunction

  // One restoring division step: shift in one dividend bit, subtract if it fits.
  // Requires rem < divisor on entry (or divisor zero, result then unused).
  function automatic word_t div_step(word_t rem, logic next_bit, word_t divisor);
    logic [DataW:0] cand;
    cand = {rem, next_bit};
    if (cand >= {1'b0, divisor}) begin
      cand = cand - {1'b0, divisor};
    end
    return cand[DataW-1:0];
  endfunction

endpackage

FILE: src/bri_stream_if.sv
// ----------------------------------------------------------------------------
// bri_stream_if: valid/ready stream channel
// Carries one payload per request; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface bri_stream_if #(
  parameter type PayloadT = logic
) ();

  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

FILE: src/bounded_random_integer.sv
// Pipeline: one entry stage, 64 division stages and one output stage; every stage
//   holds while the output register is full and not being drained.
// Throughput: one request per cycle, set by the 64-stage remainder pipeline, except
//   while the output stalls. A register write blocks requests during the write,
//   PrepBounds (latch bounds) and PrepDivide (divide out the rejection threshold).
// Reset (rst_ni low, asynchronous): bounds 0 and 1, 64-bit mode, pipeline empty.
// ----------------------------------------------------------------------------
// bounded_random_integer: unbiased bounded random integer sampler
// Maps each 64-bit random word onto [low, high) by modulo rejection:
// words below (2^64 - range) mod range are dropped, the others give
// low + (word mod range). A narrow mode works on 32-bit bounds and results.
// ----------------------------------------------------------------------------
module bounded_random_integer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  bri_pkg::cfg_idx_t  cfg_idx_i,
  input  bri_pkg::word_t     cfg_data_i,
  bri_stream_if.sink         req_i,
  bri_stream_if.source       rsp_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  bri_pkg::word_t low_q;
  bri_pkg::word_t high_q;
  logic           narrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= bri_pkg::word_t'(0);
      high_q   <= bri_pkg::word_t'(1);
      narrow_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bri_pkg::RegLowBound:   low_q    <= cfg_data_i;
        bri_pkg::RegHighBound:  high_q   <= cfg_data_i;
        bri_pkg::RegNarrowMode: narrow_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derived bounds: truncate in narrow mode, swap reversed bounds
  // --------------------------------------------------------------------------
  bri_pkg::word_t lo_n, hi_n, lo_s, hi_s;
  logic           swap;

  always_comb begin
    lo_n = narrow_q ? bri_pkg::sext_half(low_q)  : low_q;
    hi_n = narrow_q ? bri_pkg::sext_half(high_q) : high_q;
    swap = $signed(hi_n) < $signed(lo_n);
    lo_s = swap ? hi_n : lo_n;
    hi_s = swap ? lo_n : hi_n;
  end

  // --------------------------------------------------------------------------
  // Threshold preparation: after any write, latch base and range, then, for unequal
  // bounds, divide 2^64 - range by range one bit per cycle for the rejection threshold.
  // --------------------------------------------------------------------------
  bri_pkg::prep_state_e state_q, state_d;
  bri_pkg::word_t       base_q, base_d;
  bri_pkg::word_t       range_q, range_d;
  logic                 equal_q, equal_d;
  bri_pkg::word_t       thresh_q, thresh_d;
  bri_pkg::word_t       tdiv_rem_q, tdiv_rem_d;
  bri_pkg::word_t       tdiv_num_q, tdiv_num_d;
  bri_pkg::step_cnt_t   tdiv_cnt_q, tdiv_cnt_d;
  bri_pkg::word_t       tdiv_step;

  assign tdiv_step = bri_pkg::div_step(tdiv_rem_q, tdiv_num_q[bri_pkg::DataW-1], range_q);

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    range_d    = range_q;
    equal_d    = equal_q;
    thresh_d   = thresh_q;
    tdiv_rem_d = tdiv_rem_q;
    tdiv_num_d = tdiv_num_q;
    tdiv_cnt_d = tdiv_cnt_q;

    unique case (state_q)
      bri_pkg::PrepReady: ;
      bri_pkg::PrepBounds: begin
        base_d  = lo_s;
        range_d = hi_s - lo_s;
        equal_d = (lo_s == hi_s);
        if (lo_s == hi_s) begin
          // every word yields low; nothing to reject
          thresh_d = '0;
          state_d  = bri_pkg::PrepReady;
        end else begin
          tdiv_rem_d = '0;
          tdiv_num_d = '0 - (hi_s - lo_s);
          tdiv_cnt_d = '0;
          state_d    = bri_pkg::PrepDivide;
        end
      end
      bri_pkg::PrepDivide: begin
        tdiv_rem_d = tdiv_step;
        tdiv_num_d = tdiv_num_q << 1;
        tdiv_cnt_d = tdiv_cnt_q + bri_pkg::step_cnt_t'(1);
        if (tdiv_cnt_q == '1) begin
          thresh_d = tdiv_step;
          state_d  = bri_pkg::PrepReady;
        end
      end
      default: state_d = bri_pkg::PrepBounds;
    endcase

    // restart on every register write
    if (cfg_we_i) begin
      state_d = bri_pkg::PrepBounds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bri_pkg::PrepReady;
      base_q   <= '0;
      range_q  <= bri_pkg::word_t'(1);
      equal_q  <= 1'b0;
      thresh_q <= '0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      range_q  <= range_d;
      equal_q  <= equal_d;
      thresh_q <= thresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdiv_rem_q <= tdiv_rem_d;
    tdiv_num_q <= tdiv_num_d;
    tdiv_cnt_q <= tdiv_cnt_d;
  end

  // --------------------------------------------------------------------------
  // Request pipeline: the whole pipe advances when the output register is
  // free or being drained, otherwise every stage holds.
  // --------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic keep;
  logic out_valid_q;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = advance && (state_q == bri_pkg::PrepReady) && !cfg_we_i;
  assign accept      = req_i.valid && req_i.ready;
  // drop words below the threshold; equal bounds accept everything
  assign keep        = equal_q || (req_i.data.random_word >= thresh_q);

  logic [bri_pkg::DivSteps:0] vld_q;
  bri_pkg::word_t             rem_q [bri_pkg::DivSteps+1];
  bri_pkg::word_t             num_q [bri_pkg::DivSteps+1];

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rem_q[0] <= '0;
      num_q[0] <= req_i.data.random_word;
    end
  end

  // Division stages: each takes the next word bit, MSB first
  for (genvar s = 1; s <= bri_pkg::DivSteps; s++) begin : gen_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (advance) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[s] <= bri_pkg::div_step(rem_q[s-1], num_q[s-1][bri_pkg::DataW-1], range_q);
        num_q[s] <= num_q[s-1] << 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: add the base, wrap to 32 bits in narrow mode
  // --------------------------------------------------------------------------
  bri_pkg::word_t sum;
  bri_pkg::word_t result;
  bri_pkg::word_t out_data_q;

  always_comb begin
    sum = base_q + rem_q[bri_pkg::DivSteps];
    if (equal_q) begin
      result = base_q;
    end else if (narrow_q) begin
      result = bri_pkg::sext_half(sum);
    end else begin
      result = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_q[bri_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.data.sample_value = out_data_q;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the bounded random integer sampler
// Streams random words through the sampler under a series of bound settings
// (ordinary, reversed, equal, full width, narrow, random) and checks every
// sample, and every rejection, against a local model of the modulo-rejection
// mapping. Both stream ends idle at random in the early phases, and once
// the response side holds off long enough to back the pipeline up into the request side.
// ----------------------------------------------------------------------------
module tb;

  // Index past the register list: a write there must leave the registers as they are
  localparam bri_pkg::cfg_idx_t RegUnused = bri_pkg::cfg_idx_t'(3);

  localparam int unsigned NumPhases   = 19;
  localparam int unsigned StallPhase  = 12;
  localparam int unsigned StallCycles = 300;
  // Pipeline is 66 deep; give any unexpected sample still in flight time to show up
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 200000;

  localparam bri_pkg::word_t MinS64 = 64'h8000_0000_0000_0000;
  localparam bri_pkg::word_t MaxS64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // --------------------------------------------------------------------------
  // Sample scoreboard: mirrors the bound registers, maps each accepted word to
  // its expected sample (or to nothing when rejected) and checks responses in
  // order.
  // --------------------------------------------------------------------------
  class sample_scoreboard;
    bri_pkg::word_t low_reg;
    bri_pkg::word_t high_reg;
    bit             narrow;
    bri_pkg::word_t expected_samples[$];
    int unsigned    errors;

    function new();
      low_reg  = '0;
      high_reg = 64'd1;
      narrow   = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(bri_pkg::cfg_idx_t idx, bri_pkg::word_t value);
      case (idx)
        bri_pkg::RegLowBound:   low_reg  = value;
        bri_pkg::RegHighBound:  high_reg = value;
        bri_pkg::RegNarrowMode: narrow   = value[0];
        default: ;
      endcase
    endfunction

    static function bri_pkg::word_t widen_half(bri_pkg::word_t v);
      return {{32{v[31]}}, v[31:0]};
    endfunction

    // Effective bounds: truncated in narrow mode, ordered by signed compare
    function void bounds(output bri_pkg::word_t lo, output bri_pkg::word_t hi);
      bri_pkg::word_t t;
      lo = low_reg;
      hi = high_reg;
      if (narrow) begin
        lo = widen_half(lo);
        hi = widen_half(hi);
      end
      if ($signed(hi) < $signed(lo)) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    endfunction

    // Smallest word that is accepted; zero when bounds are equal
    function bri_pkg::word_t reject_limit();
      bri_pkg::word_t lo, hi, span;
      bounds(lo, hi);
      if (lo == hi) return '0;
      span = hi - lo;
      return (bri_pkg::word_t'(0) - span) % span;
    endfunction

    function bit map_word(bri_pkg::word_t w, output bri_pkg::word_t sample);
      bri_pkg::word_t lo, hi, span;
      bounds(lo, hi);
      sample = lo;
      if (lo == hi) return 1'b1;
      span = hi - lo;
      if (w < (bri_pkg::word_t'(0) - span) % span) return 1'b0;
      sample = lo + w % span;
      if (narrow) sample = widen_half(sample);
      return 1'b1;
    endfunction

    function void note_request(bri_pkg::word_t w);
      bri_pkg::word_t sample;
      if (map_word(w, sample)) expected_samples.push_back(sample);
    endfunction

    function void check_sample(bri_pkg::word_t got);
      bri_pkg::word_t want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        $display("%0t: sample mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  bri_pkg::cfg_idx_t cfg_idx;
  bri_pkg::word_t    cfg_data;

  bri_stream_if #(.PayloadT(bri_pkg::req_t)) req_if ();
  bri_stream_if #(.PayloadT(bri_pkg::rsp_t)) rsp_if ();

  sample_scoreboard sb = new();

  // Idle odds in percent, set per phase by the main sequence
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  // Raised once by the main sequence; the response side then holds off
  bit          hold_off_pending = 1'b0;
  int unsigned cycle_count = 0;

  bounded_random_integer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: fails the run at CycleLimit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Response side: check each accepted response, then pick the next ready.
  // A pending hold-off drops ready for a long stretch so the pipeline fills
  // and the request side stalls.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        sb.check_sample(bri_pkg::word_t'(rsp_if.data.sample_value));
      end
      if (hold_off_pending && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Write one register and mirror it; let the port go quiet again before returning so
  // back-to-back writes never stack two assignments in one step.
  task automatic write_cfg(bri_pkg::cfg_idx_t idx, bri_pkg::word_t value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and hold it until taken. Called at a clock edge; on
  // return the request was accepted at the current edge.
  task automatic send_word(bri_pkg::word_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= bri_pkg::req_t'(w);
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(w);
  endtask

  // Random word biased toward the interesting spots: the ends of the word
  // range, tiny words (rejections in narrow mode) and the rejection boundary.
  function automatic bri_pkg::word_t pick_word(bri_pkg::word_t limit);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return bri_pkg::word_t'($urandom_range(255));
      4, 5:    return limit - 64'd8 + bri_pkg::word_t'($urandom_range(16));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Wait out every expected sample, then leave time for any unexpected sample to show
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, then one phase per bound setting. Each phase starts
  // with the boundary words for that setting and goes on with random words.
  // --------------------------------------------------------------------------
  initial begin
    bri_pkg::word_t lo, hi, mode, span, limit;
    int unsigned    count;

    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= bri_pkg::RegLowBound;
    cfg_data     <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      // Sender idles less than receiver, then the other way round, then neither
      if (p < NumPhases / 3) begin
        src_idle_pct = 28;
        snk_idle_pct = 62;
      end else if (p < 2 * NumPhases / 3) begin
        src_idle_pct = 62;
        snk_idle_pct = 28;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      mode  = '0;
      count = 60;
      case (p)
        // Reset bounds: range of one, every word maps to zero
        0: begin lo = '0; hi = 64'd1; count = 40; end
        1: begin lo = -64'sd5; hi = 64'd10; end
        // Reversed bounds
        2: begin lo = 64'd100; hi = -64'sd100; end
        // Equal bounds: every word yields low
        3: begin lo = 64'd42; hi = 64'd42; count = 40; end
        // Full width range, rejection limit of one
        4: begin lo = MinS64; hi = MaxS64; end
        // Range just above 2^63: about half of all words rejected
        5: begin lo = 64'hC000_0000_0000_0000; hi = 64'h4000_0000_0000_0001; count = 80; end
        6: begin lo = MaxS64; hi = MinS64; end
        // Narrow mode, junk above bit 31 of both bounds, widest narrow range
        7: begin
          lo = 64'h1234_5678_8000_0000; hi = 64'hABCD_0000_7FFF_FFFF; mode = 64'd1;
        end
        // Bounds that differ only above bit 31: equal once narrowed
        8: begin
          lo = 64'h0000_0001_0000_0007; hi = 64'h0000_0002_0000_0007; mode = 64'd1;
          count = 40;
        end
        // Narrow bounds that reverse after truncation
        9: begin lo = 64'h7FFF_FFF0; hi = 64'h8000_0010; mode = 64'd1; end
        // Mode write with bit 0 clear and the rest set: stays 64-bit
        10: begin lo = -64'sd1000; hi = 64'd1000; mode = 64'hFFFF_FFFF_FFFF_FFFE; end
        // Narrow bounds that become equal once truncated
        11: begin lo = -64'sd7; hi = 64'h0000_0000_FFFF_FFF9; mode = 64'd1; end
        // Nearly rejection-free range used while the response side holds off
        StallPhase: begin lo = '0; hi = MaxS64; count = 160; end
        default: begin
          lo = {$urandom, $urandom};
          case ($urandom_range(2))
            0:       span = bri_pkg::word_t'($urandom_range(1, 20));
            1:       span = bri_pkg::word_t'($urandom);
            default: span = {1'b1, 31'($urandom), $urandom};
          endcase
          hi    = lo + span;
          mode  = {$urandom, $urandom};
          count = 80;
        end
      endcase

      if (p > 0) begin
        write_cfg(bri_pkg::RegLowBound, lo);
        write_cfg(bri_pkg::RegHighBound, hi);
        write_cfg(bri_pkg::RegNarrowMode, mode);
        if (p == 10) write_cfg(RegUnused, '1);
      end
      if (p == StallPhase) hold_off_pending = 1'b1;

      // Boundary words for this setting
      limit = sb.reject_limit();
      send_word('0);
      send_word('1);
      send_word(MinS64);
      send_word(limit - 64'd1);
      send_word(limit);
      send_word(limit + 64'd1);

      repeat (count) send_word(pick_word(limit));
      req_if.valid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bri_pkg.sv
src/bri_stream_if.sv
src/bounded_random_integer.sv
bench/tb.sv
